>>> sv/tvbb_pkg.sv
package tvbb_pkg;

    // One input item as it arrives on the input channel.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               has_vertex;
        logic               last_item;
    } t_vtx_in;

    // One result item: the finished box of a mesh.
    typedef struct packed {
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
        logic               clipped;
    } t_box_out;

    // Control that travels down the transform pipeline beside the data.
    typedef struct packed {
        logic valid;
        logic has_vertex;
        logic last_item;
    } t_tag;

    // Queue status seen by the front end and the top level.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 64;
    localparam int NUM_REGS      = 6;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ROW0_A = 3'd0,
        REG_ROW0_B = 3'd1,
        REG_ROW1_A = 3'd2,
        REG_ROW1_B = 3'd3,
        REG_ROW2_A = 3'd4,
        REG_ROW2_B = 3'd5
    } t_reg_idx;

    // Reset values give the identity transform.
    localparam logic [CFG_DATA_BITS-1:0] RST_ROW0_A = 64'h0001_0000_0000_0000;
    localparam logic [CFG_DATA_BITS-1:0] RST_ROW0_B = 64'h0000_0000_0000_0000;
    localparam logic [CFG_DATA_BITS-1:0] RST_ROW1_A = 64'h0000_0000_0001_0000;
    localparam logic [CFG_DATA_BITS-1:0] RST_ROW1_B = 64'h0000_0000_0000_0000;
    localparam logic [CFG_DATA_BITS-1:0] RST_ROW2_A = 64'h0000_0000_0000_0000;
    localparam logic [CFG_DATA_BITS-1:0] RST_ROW2_B = 64'h0001_0000_0000_0000;

    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_PTR_BITS   = 2;
    localparam int FIFO_COUNT_BITS = FIFO_PTR_BITS + 1;

endpackage

>>> sv/tvbb_front.sv
module tvbb_front
    import tvbb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_vtx_in i_in_data,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_vtx_in o_push_data
);

    logic    r_valid;
    t_vtx_in r_item;
    logic    w_accept;
    logic    w_useful;

    assign o_in_ready = !r_valid || !i_q_stat.full;
    assign w_accept   = i_in_valid && o_in_ready;
    // An item with no vertex that does not close the mesh changes nothing.
    assign w_useful   = i_in_data.has_vertex || i_in_data.last_item;

    assign o_push      = r_valid && !i_q_stat.full;
    assign o_push_data = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= w_useful;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
        end
    end

endmodule

>>> sv/tvbb_fifo.sv
module tvbb_fifo
    import tvbb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_vtx_in i_push_data,
    input  logic    i_pop,
    output t_vtx_in o_pop_data,
    output t_q_stat o_stat
);

    t_vtx_in                    r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0]   r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0]   r_rd_ptr;
    logic [FIFO_COUNT_BITS-1:0] r_count;

    assign o_stat.full  = (r_count == FIFO_COUNT_BITS'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_pop_data   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> sv/tvbb_xform.sv
module tvbb_xform
    import tvbb_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic                         i_adv,
    input  logic                         i_load,
    input  t_vtx_in                      i_data,
    output t_tag                         o_tag,
    output logic signed [COORD_BITS-1:0] o_coord [3],
    output logic                         o_sat
);

    localparam int PW = 2 * COORD_BITS;
    localparam int SW = PW + 2;
    localparam int QW = SW - FRAC_BITS;
    localparam int TW = ((QW > COORD_BITS) ? QW : COORD_BITS) + 1;

    localparam logic signed [SW-1:0] HALF =
        {{(SW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [TW-1:0] MAXV =
        {{(TW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [TW-1:0] MINV =
        {{(TW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    logic [CFG_DATA_BITS-1:0]     r_cfg [NUM_REGS];
    logic signed [COORD_BITS-1:0] w_m   [3][3];
    logic signed [COORD_BITS-1:0] w_t   [3];
    logic signed [COORD_BITS-1:0] w_p   [3];

    logic signed [PW-1:0]         r_prod [3][3];
    logic signed [SW-1:0]         w_sum  [3];
    logic signed [QW-1:0]         r_rnd  [3];
    logic signed [TW-1:0]         w_tr   [3];
    logic signed [COORD_BITS-1:0] w_res  [3];
    logic                         w_sat;
    logic signed [COORD_BITS-1:0] r_res  [3];
    logic                         r_sat;

    t_tag r_tag1;
    t_tag r_tag2;
    t_tag r_tag3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_ROW0_A] <= RST_ROW0_A;
            r_cfg[REG_ROW0_B] <= RST_ROW0_B;
            r_cfg[REG_ROW1_A] <= RST_ROW1_A;
            r_cfg[REG_ROW1_B] <= RST_ROW1_B;
            r_cfg[REG_ROW2_A] <= RST_ROW2_A;
            r_cfg[REG_ROW2_B] <= RST_ROW2_B;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROW0_A: r_cfg[REG_ROW0_A] <= i_cfg_data;
                REG_ROW0_B: r_cfg[REG_ROW0_B] <= i_cfg_data;
                REG_ROW1_A: r_cfg[REG_ROW1_A] <= i_cfg_data;
                REG_ROW1_B: r_cfg[REG_ROW1_B] <= i_cfg_data;
                REG_ROW2_A: r_cfg[REG_ROW2_A] <= i_cfg_data;
                REG_ROW2_B: r_cfg[REG_ROW2_B] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Each register half holds one coefficient; only its low bits count.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_m[r][0] = r_cfg[2*r][32 +: COORD_BITS];
            w_m[r][1] = r_cfg[2*r][0 +: COORD_BITS];
            w_m[r][2] = r_cfg[2*r+1][32 +: COORD_BITS];
            w_t[r]    = r_cfg[2*r+1][0 +: COORD_BITS];
        end
    end

    assign w_p[0] = i_data.pos_x[COORD_BITS-1:0];
    assign w_p[1] = i_data.pos_y[COORD_BITS-1:0];
    assign w_p[2] = i_data.pos_z[COORD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else if (i_adv) begin
            r_tag1.valid      <= i_load;
            r_tag1.has_vertex <= i_data.has_vertex;
            r_tag1.last_item  <= i_data.last_item;
            r_tag2            <= r_tag1;
            r_tag3            <= r_tag2;
        end
    end

    // The three exact products are summed with one half LSB added, so the
    // slice below gives the sum rounded half toward plus infinity.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_sum[r] = SW'(r_prod[r][0]) + SW'(r_prod[r][1])
                     + SW'(r_prod[r][2]) + HALF;
        end
    end

    always_comb begin
        w_sat = 1'b0;
        for (int r = 0; r < 3; r++) begin
            w_tr[r] = TW'(r_rnd[r]) + TW'(w_t[r]);
            if (w_tr[r] > MAXV) begin
                w_res[r] = MAXV[COORD_BITS-1:0];
                w_sat    = 1'b1;
            end else if (w_tr[r] < MINV) begin
                w_res[r] = MINV[COORD_BITS-1:0];
                w_sat    = 1'b1;
            end else begin
                w_res[r] = w_tr[r][COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= PW'(w_m[r][c]) * PW'(w_p[c]);
                end
                r_rnd[r] <= w_sum[r][SW-1:FRAC_BITS];
                r_res[r] <= w_res[r];
            end
            r_sat <= w_sat;
        end
    end

    assign o_tag   = r_tag3;
    assign o_coord = r_res;
    assign o_sat   = r_sat;

endmodule

>>> sv/tvbb_accum.sv
module tvbb_accum
    import tvbb_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_tag                         i_tag,
    input  logic signed [COORD_BITS-1:0] i_coord [3],
    input  logic                         i_sat,
    output logic                         o_adv,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output t_box_out                     o_out_data
);

    localparam logic signed [COORD_BITS-1:0] MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic signed [COORD_BITS-1:0] r_min [3];
    logic signed [COORD_BITS-1:0] r_max [3];
    logic                         r_seen;
    logic                         r_satd;
    logic                         r_out_valid;
    t_box_out                     r_out;

    logic signed [COORD_BITS-1:0] n_min [3];
    logic signed [COORD_BITS-1:0] n_max [3];
    logic                         n_seen;
    logic                         n_satd;
    logic                         w_take;
    logic                         w_vtx;
    t_box_out                     w_box;

    // Only a closing item has to wait for the output register to drain.
    assign o_adv  = !(i_tag.valid && i_tag.last_item && r_out_valid && !i_out_ready);
    assign w_take = i_tag.valid && o_adv;
    assign w_vtx  = i_tag.valid && i_tag.has_vertex;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_min[a] = (w_vtx && (i_coord[a] < r_min[a])) ? i_coord[a] : r_min[a];
            n_max[a] = (w_vtx && (i_coord[a] > r_max[a])) ? i_coord[a] : r_max[a];
        end
        n_seen = r_seen || w_vtx;
        n_satd = r_satd || (w_vtx && i_sat);
    end

    always_comb begin
        w_box = '0;
        if (n_seen) begin
            w_box.box_min_x = 32'(n_min[0]);
            w_box.box_min_y = 32'(n_min[1]);
            w_box.box_min_z = 32'(n_min[2]);
            w_box.box_max_x = 32'(n_max[0]);
            w_box.box_max_y = 32'(n_max[1]);
            w_box.box_max_z = 32'(n_max[2]);
        end
        w_box.clipped = n_satd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= MAXV;
                r_max[a] <= MINV;
            end
            r_seen      <= 1'b0;
            r_satd      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take && i_tag.last_item) begin
                for (int a = 0; a < 3; a++) begin
                    r_min[a] <= MAXV;
                    r_max[a] <= MINV;
                end
                r_seen      <= 1'b0;
                r_satd      <= 1'b0;
                r_out_valid <= 1'b1;
            end else begin
                if (w_take) begin
                    r_min  <= n_min;
                    r_max  <= n_max;
                    r_seen <= n_seen;
                    r_satd <= n_satd;
                end
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_tag.last_item) begin
            r_out <= w_box;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sv/transformed_vertex_bounding_box_unit.sv
// Streams vertex positions through a configured 3x4 affine transform and
// returns the per-axis bounding box of each mesh when its last item arrives.
// One item is accepted per clock cycle unless a full queue holds the input
// register; the rate is set by a pipeline of nine parallel multipliers
// followed by a sum-and-round stage and a translate-and-saturate stage,
// feeding the registered min/max update. Items pass through an input
// register and a four-entry queue, so the input keeps flowing while a box
// waits on the output; only a following closing item stalls behind it.
// Items without a vertex that do not close a mesh are dropped on entry.
// Write the transform registers only while no items are in flight.
module transformed_vertex_bounding_box_unit
    import tvbb_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_vtx_in                  i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_box_out                 o_out_data,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    logic                         w_push;
    t_vtx_in                      w_push_data;
    t_vtx_in                      w_pop_data;
    t_q_stat                      w_q_stat;
    logic                         w_pop;
    logic                         w_adv;
    t_tag                         w_tag;
    logic signed [COORD_BITS-1:0] w_coord [3];
    logic                         w_sat;

    tvbb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    tvbb_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_stat      (w_q_stat)
    );

    assign w_pop = w_adv && !w_q_stat.empty;

    tvbb_xform #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_xform (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_adv       (w_adv),
        .i_load      (w_pop),
        .i_data      (w_pop_data),
        .o_tag       (w_tag),
        .o_coord     (w_coord),
        .o_sat       (w_sat)
    );

    tvbb_accum #(
        .COORD_BITS (COORD_BITS)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (w_tag),
        .i_coord     (w_coord),
        .i_sat       (w_sat),
        .o_adv       (w_adv),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_stat.full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_q_stat.empty))
        else $error("queue read while empty");

    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.box_min_x <= o_out_data.box_max_x)
                     && (o_out_data.box_min_y <= o_out_data.box_max_y)
                     && (o_out_data.box_min_z <= o_out_data.box_max_z))
        else $error("box minimum exceeds maximum");

    a_closing_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |-> (w_tag.valid && w_tag.last_item && o_out_valid))
        else $error("pipeline stalled without a waiting box");

endmodule

>>> verif/tvbb_box_checker.sv
`timescale 1ns / 1ps

module tvbb_box_checker
    import tvbb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  t_vtx_in                  i_in_data,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  t_box_out                 i_out_data,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam int FRAC        = 16;

    localparam logic signed [79:0] ROUND_HALF = 80'sd1 <<< (FRAC - 1);
    localparam logic signed [79:0] SAT_HI     = 80'sd2147483647;
    localparam logic signed [79:0] SAT_LO     = -80'sd2147483648;
    localparam logic signed [31:0] COORD_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COORD_MIN  = 32'sh8000_0000;

    logic [CFG_DATA_BITS-1:0] xform_regs [NUM_REGS];
    t_box_out                 mesh_box;
    logic                     mesh_has_pts;
    t_box_out                 box_expect_q [$];

    // One row of the affine transform: exact products, one rounding, then the
    // translation, then saturation to the signed 32-bit range.
    function automatic logic signed [31:0] xform_axis(
        input  logic [63:0]        lin_a,
        input  logic [63:0]        lin_b,
        input  logic signed [31:0] px,
        input  logic signed [31:0] py,
        input  logic signed [31:0] pz,
        output logic               sat
    );
        logic signed [31:0] ca;
        logic signed [31:0] cb;
        logic signed [31:0] cc;
        logic signed [31:0] tr;
        logic signed [79:0] acc;
        ca  = lin_a[63:32];
        cb  = lin_a[31:0];
        cc  = lin_b[63:32];
        tr  = lin_b[31:0];
        acc = ca * px + cb * py + cc * pz + ROUND_HALF;
        acc = (acc >>> FRAC) + tr;
        sat = 1'b0;
        if (acc > SAT_HI) begin
            sat = 1'b1;
            return COORD_MAX;
        end
        if (acc < SAT_LO) begin
            sat = 1'b1;
            return COORD_MIN;
        end
        return acc[31:0];
    endfunction

    function automatic void clear_mesh();
        mesh_box.box_min_x = COORD_MAX;
        mesh_box.box_min_y = COORD_MAX;
        mesh_box.box_min_z = COORD_MAX;
        mesh_box.box_max_x = COORD_MIN;
        mesh_box.box_max_y = COORD_MIN;
        mesh_box.box_max_z = COORD_MIN;
        mesh_box.clipped   = 1'b0;
        mesh_has_pts       = 1'b0;
    endfunction

    task automatic check_field(input string nm, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: box field %s expected %h, got %h", $time, nm, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_box_out           want;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic               sx;
        logic               sy;
        logic               sz;
        if (!i_rst_n) begin
            xform_regs[REG_ROW0_A] = RST_ROW0_A;
            xform_regs[REG_ROW0_B] = RST_ROW0_B;
            xform_regs[REG_ROW1_A] = RST_ROW1_A;
            xform_regs[REG_ROW1_B] = RST_ROW1_B;
            xform_regs[REG_ROW2_A] = RST_ROW2_A;
            xform_regs[REG_ROW2_B] = RST_ROW2_B;
            clear_mesh();
            box_expect_q.delete();
            o_fail_count = 0;
        end else begin
            // Writes to indexes past the last register are dropped.
            if (i_cfg_we && i_cfg_index < NUM_REGS) begin
                xform_regs[i_cfg_index] = i_cfg_data;
            end

            // Retire the outgoing item first so that it is matched against
            // boxes predicted in earlier cycles only.
            if (i_out_valid && i_out_ready) begin
                if (box_expect_q.size() == 0) begin
                    $display("%0t: box expected none, got %h", $time, i_out_data);
                    o_fail_count++;
                end else begin
                    want = box_expect_q.pop_front();
                    check_field("box_min_x", want.box_min_x, i_out_data.box_min_x);
                    check_field("box_min_y", want.box_min_y, i_out_data.box_min_y);
                    check_field("box_min_z", want.box_min_z, i_out_data.box_min_z);
                    check_field("box_max_x", want.box_max_x, i_out_data.box_max_x);
                    check_field("box_max_y", want.box_max_y, i_out_data.box_max_y);
                    check_field("box_max_z", want.box_max_z, i_out_data.box_max_z);
                    check_field("clipped", 32'(want.clipped), 32'(i_out_data.clipped));
                end
            end

            if (i_in_valid && i_in_ready) begin
                if (i_in_data.has_vertex) begin
                    tx = xform_axis(xform_regs[REG_ROW0_A], xform_regs[REG_ROW0_B],
                                    i_in_data.pos_x, i_in_data.pos_y, i_in_data.pos_z, sx);
                    ty = xform_axis(xform_regs[REG_ROW1_A], xform_regs[REG_ROW1_B],
                                    i_in_data.pos_x, i_in_data.pos_y, i_in_data.pos_z, sy);
                    tz = xform_axis(xform_regs[REG_ROW2_A], xform_regs[REG_ROW2_B],
                                    i_in_data.pos_x, i_in_data.pos_y, i_in_data.pos_z, sz);
                    if (tx < mesh_box.box_min_x) mesh_box.box_min_x = tx;
                    if (ty < mesh_box.box_min_y) mesh_box.box_min_y = ty;
                    if (tz < mesh_box.box_min_z) mesh_box.box_min_z = tz;
                    if (tx > mesh_box.box_max_x) mesh_box.box_max_x = tx;
                    if (ty > mesh_box.box_max_y) mesh_box.box_max_y = ty;
                    if (tz > mesh_box.box_max_z) mesh_box.box_max_z = tz;
                    mesh_box.clipped = mesh_box.clipped | sx | sy | sz;
                    mesh_has_pts     = 1'b1;
                end
                // A mesh with no vertex closes with an all-zero box.
                if (i_in_data.last_item) begin
                    want = mesh_has_pts ? mesh_box : '0;
                    box_expect_q.push_back(want);
                    clear_mesh();
                end
            end
        end
        o_pending = box_expect_q.size();
    end

endmodule

>>> verif/tb_transformed_vertex_bounding_box_unit.sv
`timescale 1ns / 1ps

module tb_transformed_vertex_bounding_box_unit;
    import tvbb_pkg::*;

    localparam int HALF_PERIOD      = 5;
    localparam int RESET_CYCLES     = 11;
    localparam int SETTLE_CYCLES    = 20;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int PHASE_COUNT      = 8;
    localparam int PHASE_ITEMS      = 100;
    localparam int PRESSURE_ITEMS   = 40;
    localparam int MESH_END_ODDS    = 8;
    localparam int VERTEX_PCT       = 85;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = CFG_IDX_BITS'(NUM_REGS);
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = CFG_IDX_BITS'(NUM_REGS + 1);

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    t_vtx_in                  in_data   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    t_box_out                 out_data;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    int fail_cnt;
    int boxes_pending;
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int hold_requests = 0;
    int hold_taken    = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    logic [CFG_DATA_BITS-1:0] cfg_plan [NUM_REGS];

    always #HALF_PERIOD clk = ~clk;

    transformed_vertex_bounding_box_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    tvbb_box_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_cnt),
        .o_pending    (boxes_pending)
    );

    // Output side: random stalls, or one long hold-off when asked for.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (hold_taken != hold_requests) begin
            hold_taken = hold_requests;
            hold_left  = LONG_HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_vtx_in vtx(input logic [31:0] x, input logic [31:0] y,
                                    input logic [31:0] z, input logic v, input logic l);
        t_vtx_in it;
        it.pos_x      = x;
        it.pos_y      = y;
        it.pos_z      = z;
        it.has_vertex = v;
        it.last_item  = l;
        return it;
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return '1;
            7:       return $urandom;
            default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return Q_ONE;
            2:       return -Q_ONE;
            3:       return Q_MAX;
            4:       return Q_MIN;
            7:       return $urandom;
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic t_vtx_in random_item(input int end_odds);
        return vtx(pick_coord(), pick_coord(), pick_coord(),
                   $urandom_range(0, 99) < VERTEX_PCT,
                   $urandom_range(0, end_odds - 1) == 0);
    endfunction

    // Starts and ends at a falling edge; valid stays high into the next item.
    task automatic send_item(input t_vtx_in it);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Stop sending, let every box come back, then give the pipeline time to
    // retire items that produce no box.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (boxes_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_config();
        for (int r = 0; r < NUM_REGS; r++) begin
            cfg_we    <= 1'b1;
            cfg_index <= t_reg_idx'(r);
            cfg_data  <= cfg_plan[r];
            @(negedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_index <= $urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO;
        cfg_data  <= {$urandom, $urandom};
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idle(input t_idle_mode m);
        case (m)
            IDLE_NONE: begin
                snd_idle_pct   = 0;
                rcv_stall_pct <= 0;
            end
            IDLE_SEND: begin
                snd_idle_pct   = 56;
                rcv_stall_pct <= 0;
            end
            IDLE_RECV: begin
                snd_idle_pct   = 0;
                rcv_stall_pct <= 56;
            end
            default: begin
                snd_idle_pct   = 7;
                rcv_stall_pct <= 7;
            end
        endcase
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Identity transform from reset.
        set_idle(IDLE_NONE);
        send_item(vtx($urandom, $urandom, $urandom, 1'b0, 1'b1));
        send_item(vtx(Q_MAX, Q_MIN, '0, 1'b1, 1'b0));
        send_item(vtx(Q_MIN, Q_MAX, '1, 1'b1, 1'b0));
        send_item(vtx($urandom, $urandom, $urandom, 1'b0, 1'b0));
        send_item(vtx('0, '0, Q_MAX, 1'b1, 1'b1));
        send_item(vtx(pick_coord(), pick_coord(), pick_coord(), 1'b1, 1'b1));
        send_item(vtx('0, '0, '0, 1'b0, 1'b1));
        send_item(vtx(Q_MIN, Q_MIN, Q_MIN, 1'b0, 1'b0));
        send_item(vtx($urandom, $urandom, $urandom, 1'b0, 1'b1));
        drain();

        // Large coefficients and translations that drive the x and y axes into
        // saturation in both directions; the z axis stays in range.
        cfg_plan[REG_ROW0_A] = {32'h0002_0000, 32'h0000_0000};
        cfg_plan[REG_ROW0_B] = {32'h0000_8000, Q_MAX};
        cfg_plan[REG_ROW1_A] = {Q_MIN, Q_MAX};
        cfg_plan[REG_ROW1_B] = {Q_MIN, Q_MIN};
        cfg_plan[REG_ROW2_A] = {32'hFFFF_FFFF, 32'h0000_0001};
        cfg_plan[REG_ROW2_B] = {Q_ONE, 32'h0000_0000};
        load_config();
        send_item(vtx(Q_MAX, Q_MAX, Q_MAX, 1'b1, 1'b0));
        send_item(vtx(Q_MIN, Q_MIN, Q_MIN, 1'b1, 1'b0));
        send_item(vtx(32'h0000_0001, '1, 32'h1234_5678, 1'b1, 1'b1));
        send_item(vtx('0, '0, '0, 1'b1, 1'b1));
        send_item(vtx(Q_MAX, Q_MIN, Q_MAX, 1'b1, 1'b1));
        send_item(vtx('0, '0, '0, 1'b0, 1'b1));
        drain();

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            for (int r = 0; r < NUM_REGS; r++) begin
                case (ph)
                    1:       cfg_plan[r] = '0;
                    2:       cfg_plan[r] = '1;
                    3:       cfg_plan[r] = {Q_MAX, Q_MAX};
                    4:       cfg_plan[r] = {Q_MIN, Q_MIN};
                    default: cfg_plan[r] = {pick_coef(), pick_coef()};
                endcase
            end
            load_config();
            set_idle(t_idle_mode'(ph % 4));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph % 2 == 1 && k == PHASE_ITEMS / 2) begin
                    drain();
                end
                send_item(random_item(MESH_END_ODDS));
            end
            drain();
        end

        // Hold the output off while closing items keep coming, so the block
        // fills up and has to stall its input.
        set_idle(IDLE_NONE);
        hold_requests <= hold_requests + 1;
        for (int k = 0; k < PRESSURE_ITEMS; k++) begin
            send_item(random_item(2));
        end
        drain();

        if (fail_cnt == 0 && boxes_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
